// File: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef struct packed {
    logic insert;
    logic pop;
  } spq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/stable_priority_queue.sv
// Stable priority queue, up to DEPTH entries held sorted, highest priority first;
// equal priorities leave in arrival order.
// Input channel: in_valid_i / in_stall_o with opcode_i (insert or pop),
// priority_req_i and message_tag_i. Each accepted beat yields one result beat.
// Output channel: out_valid_o / out_stall_i with popped_tag_o, popped_priority_o,
// pop_valid_o, error_code_o and occupancy_o.
// Storage is a row of cells; an insert or pop updates every cell at once, each
// cell comparing against the new priority and shifting from its neighbor.
// Each result is registered in the two-entry output buffer before it reaches the output.
// Throughput: one item per cycle while the receiver takes results.
// A pop on an empty queue reports an empty error; an insert into a full queue
// is dropped and reports a full error.
// Reset empties the queue and the two-entry output buffer.
// When the receiver stalls, up to two results are held; after that in_stall_o
// rises until a result is taken.
`default_nettype none

module stable_priority_queue import spq_pkg::*; #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TAG_BITS      = 32,
  localparam int CW           = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     opcode_i,
  input  wire logic [PRIORITY_BITS-1:0] priority_req_i,
  input  wire logic [TAG_BITS-1:0]      message_tag_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [TAG_BITS-1:0]           popped_tag_o,
  output logic [PRIORITY_BITS-1:0]      popped_priority_o,
  output logic                          pop_valid_o,
  output logic [1:0]                    error_code_o,
  output logic [CW-1:0]                 occupancy_o
);

  localparam int RW = TAG_BITS + PRIORITY_BITS + 1 + 2 + CW;

  logic [CW-1:0]            count_q, count_d;
  logic                     accept, is_pop, full, empty;
  spq_ctrl_t                ctrl;
  logic [PRIORITY_BITS-1:0] prio_w [DEPTH];
  logic [TAG_BITS-1:0]      tag_w  [DEPTH];
  logic [DEPTH-1:0]         ge_w;
  logic [TAG_BITS-1:0]      res_tag;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic                     res_valid;
  err_e                     res_err;
  logic [RW-1:0]            res_word, out_word;
  logic                     fifo_full;

  assign accept = in_valid_i && !in_stall_o;
  assign is_pop = (op_e'(opcode_i) == OP_POP);
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  assign ctrl.insert = accept && !is_pop && !full;
  assign ctrl.pop    = accept && is_pop && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_ge;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;
    logic [TAG_BITS-1:0]      left_tag, right_tag;

    if (i == 0) begin : g_first
      assign left_ge   = 1'b1;
      assign left_prio = priority_req_i;
      assign left_tag  = message_tag_i;
    end else begin : g_mid
      assign left_ge   = ge_w[i-1];
      assign left_prio = prio_w[i-1];
      assign left_tag  = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_prio = prio_w[i];
      assign right_tag  = tag_w[i];
    end else begin : g_inner
      assign right_prio = prio_w[i+1];
      assign right_tag  = tag_w[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .TAG_BITS     (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_prio_i  (priority_req_i),
      .new_tag_i   (message_tag_i),
      .occ_i       (CW'(i) < count_q),
      .left_ge_i   (left_ge),
      .left_prio_i (left_prio),
      .left_tag_i  (left_tag),
      .right_prio_i(right_prio),
      .right_tag_i (right_tag),
      .ge_o        (ge_w[i]),
      .prio_o      (prio_w[i]),
      .tag_o       (tag_w[i])
    );
  end

  always_comb begin
    res_tag   = '0;
    res_prio  = '0;
    res_valid = 1'b0;
    res_err   = ERR_NONE;
    if (is_pop) begin
      if (empty) begin
        res_err = ERR_EMPTY;
      end else begin
        res_tag   = tag_w[0];
        res_prio  = prio_w[0];
        res_valid = 1'b1;
      end
    end else if (full) begin
      res_err = ERR_FULL;
    end
  end

  assign res_word = {res_tag, res_prio, res_valid, res_err, count_d};

  spq_out_fifo #(
    .WIDTH(RW)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (res_word),
    .full_o (fifo_full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_word)
  );

  assign in_stall_o = fifo_full;
  assign {popped_tag_o, popped_priority_o, pop_valid_o, error_code_o, occupancy_o} = out_word;

endmodule

`default_nettype wire

// File: rtl/spq_cell.sv
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int PRIORITY_BITS = 8,
  parameter int TAG_BITS      = 32
) (
  input  wire logic                     clk_i,
  input  wire spq_ctrl_t                ctrl_i,
  input  wire logic [PRIORITY_BITS-1:0] new_prio_i,
  input  wire logic [TAG_BITS-1:0]      new_tag_i,
  input  wire logic                     occ_i,
  input  wire logic                     left_ge_i,
  input  wire logic [PRIORITY_BITS-1:0] left_prio_i,
  input  wire logic [TAG_BITS-1:0]      left_tag_i,
  input  wire logic [PRIORITY_BITS-1:0] right_prio_i,
  input  wire logic [TAG_BITS-1:0]      right_tag_i,
  output logic                          ge_o,
  output logic [PRIORITY_BITS-1:0]      prio_o,
  output logic [TAG_BITS-1:0]           tag_o
);

  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;

  assign ge_o   = occ_i && (prio_q >= new_prio_i);
  assign prio_o = prio_q;
  assign tag_o  = tag_q;

  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (ctrl_i.insert && !ge_o) begin
      if (left_ge_i) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end else begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end
    end else if (ctrl_i.pop) begin
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

endmodule

`default_nettype wire

// File: rtl/spq_out_fifo.sv
`default_nettype none

module spq_out_fifo #(
  parameter int WIDTH = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire
